/* sv/i2crs_pkg.sv */
package i2crs_pkg;

	// action codes carried in s_tuser
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_EVENT = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	// peripheral status bit positions
	localparam int ST_SB   = 0;
	localparam int ST_ADDR = 1;
	localparam int ST_BTF  = 2;
	localparam int ST_RXNE = 6;
	localparam int ST_TXE  = 7;

	// ack_ctrl codes
	localparam logic [1:0] ACK_KEEP      = 2'd0;
	localparam logic [1:0] ACK_ON        = 2'd1;
	localparam logic [1:0] ACK_NACK_STOP = 2'd2;

	// buf_irq_ctrl codes
	localparam logic [1:0] BUF_KEEP    = 2'd0;
	localparam logic [1:0] BUF_ENABLE  = 2'd1;
	localparam logic [1:0] BUF_DISABLE = 2'd2;

	localparam logic [15:0] WD_TICKS_RESET = 16'd1000;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 40;

	// input word, tdata part (first field in the high bits)
	typedef struct packed {
		logic [7:0]  rx_data;
		logic [15:0] status;
		logic [7:0]  length;
		logic [7:0]  reg_addr;
		logic [7:0]  bus_addr;
	} in_data_t;

	// input word as held in the input register
	typedef struct packed {
		logic [1:0] action;
		in_data_t   data;
	} item_t;

	// result word (first field in the high bits), 38 bits
	typedef struct packed {
		logic [3:0] failed_phase;
		logic       error_flag;
		logic       busy_res;
		logic [7:0] rx_index;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic [1:0] buf_irq_ctrl;
		logic [1:0] ack_ctrl;
		logic       stop_req;
		logic       start_req;
		logic       tx_write;
		logic [7:0] tx_byte;
	} result_t;

endpackage

/* sv/i2crs_in_reg.sv */
module i2crs_in_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  i2crs_pkg::item_t      in_item,
	output logic                  item_valid,
	input  logic                  item_take,
	output i2crs_pkg::item_t      item
);

	logic             valid_s1;
	i2crs_pkg::item_t item_s1;

	// accept a new word when empty or when the held word moves on
	assign in_ready   = !valid_s1 || item_take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* sv/i2crs_seq.sv */
module i2crs_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [15:0]           cfg_wr_data,
	input  logic                  item_valid,
	output logic                  item_take,
	input  i2crs_pkg::item_t      item,
	output logic                  res_valid,
	input  logic                  res_ready,
	output i2crs_pkg::result_t    res
);

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_ERROR    = 4'd1,
		PH_START_TX = 4'd2,
		PH_ADDR_TX  = 4'd3,
		PH_REG_TX   = 4'd4,
		PH_BTF_TX   = 4'd5,
		PH_START_RX = 4'd6,
		PH_ADDR_RX  = 4'd7,
		PH_DATA_RX  = 4'd8,
		PH_LAST_RX  = 4'd9,
		PH_WATCHDOG = 4'd10
	} phase_t;

	phase_t      phase_q, phase_n;
	phase_t      err_phase_q, err_phase_n, fail_where;
	logic [7:0]  bus_addr_q, bus_addr_n;
	logic [7:0]  reg_addr_q, reg_addr_n;
	logic [7:0]  burst_len_q, burst_len_n;
	logic [7:0]  rx_cnt_q, rx_cnt_n, rx_cnt_inc;
	logic [15:0] wd_ticks_q;
	logic [15:0] wd_cnt_q, wd_cnt_n;
	logic        wd_run_q, wd_run_n;
	logic        arm, fail;
	logic        res_valid_q;
	i2crs_pkg::result_t res_q, res_d;
	logic [15:0] st;

	// a word moves on when the result register is free or being drained
	assign item_take = item_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign st         = item.data.status;
	assign rx_cnt_inc = rx_cnt_q + 8'd1;

	// next state and result for the held word
	always_comb begin
		res_d       = '0;
		phase_n     = phase_q;
		err_phase_n = err_phase_q;
		bus_addr_n  = bus_addr_q;
		reg_addr_n  = reg_addr_q;
		burst_len_n = burst_len_q;
		rx_cnt_n    = rx_cnt_q;
		wd_cnt_n    = wd_cnt_q;
		wd_run_n    = wd_run_q;
		arm         = 1'b0;
		fail        = 1'b0;
		fail_where  = PH_IDLE;

		case (item.action)
			i2crs_pkg::ACT_START: begin
				// ignored while a burst is running
				if (phase_q == PH_IDLE || phase_q == PH_ERROR) begin
					phase_n            = PH_START_TX;
					bus_addr_n         = item.data.bus_addr;
					reg_addr_n         = item.data.reg_addr;
					burst_len_n        = item.data.length;
					rx_cnt_n           = '0;
					res_d.buf_irq_ctrl = i2crs_pkg::BUF_ENABLE;
					arm                = 1'b1;
				end
			end
			i2crs_pkg::ACT_EVENT: begin
				case (phase_q)
					PH_START_TX: begin
						res_d.tx_byte  = bus_addr_q;
						res_d.tx_write = 1'b1;
						if (st[i2crs_pkg::ST_SB]) begin
							phase_n = PH_ADDR_TX;
						end else begin
							fail       = 1'b1;
							fail_where = PH_START_TX;
						end
					end
					PH_ADDR_TX: begin
						if (st[i2crs_pkg::ST_ADDR]) begin
							phase_n = PH_REG_TX;
						end else begin
							fail       = 1'b1;
							fail_where = PH_ADDR_TX;
						end
					end
					PH_REG_TX: begin
						res_d.tx_byte      = reg_addr_q;
						res_d.tx_write     = 1'b1;
						res_d.buf_irq_ctrl = i2crs_pkg::BUF_DISABLE;
						if (st[i2crs_pkg::ST_TXE]) begin
							phase_n = PH_BTF_TX;
						end else begin
							fail       = 1'b1;
							fail_where = PH_REG_TX;
						end
					end
					PH_BTF_TX: begin
						if (st[i2crs_pkg::ST_BTF]) begin
							arm     = 1'b1;
							phase_n = PH_START_RX;
						end else begin
							fail       = 1'b1;
							fail_where = PH_BTF_TX;
						end
					end
					PH_START_RX: begin
						// a failed repeated START is simply retried
						if (st[i2crs_pkg::ST_SB]) begin
							res_d.tx_byte  = bus_addr_q | 8'h01;
							res_d.tx_write = 1'b1;
							phase_n        = PH_ADDR_RX;
						end else begin
							arm = 1'b1;
						end
					end
					PH_ADDR_RX: begin
						res_d.ack_ctrl = i2crs_pkg::ACK_ON;
						if (st[i2crs_pkg::ST_ADDR]) begin
							phase_n            = PH_DATA_RX;
							res_d.buf_irq_ctrl = i2crs_pkg::BUF_ENABLE;
						end else begin
							fail       = 1'b1;
							fail_where = PH_ADDR_RX;
						end
					end
					PH_DATA_RX: begin
						// byte goes out even when the status check fails
						res_d.rx_byte  = item.data.rx_data;
						res_d.rx_valid = 1'b1;
						res_d.rx_index = rx_cnt_q;
						rx_cnt_n       = rx_cnt_inc;
						if (st[i2crs_pkg::ST_RXNE]) begin
							if (({1'b0, rx_cnt_inc} + 9'd1) >= {1'b0, burst_len_q}) begin
								phase_n        = PH_LAST_RX;
								res_d.ack_ctrl = i2crs_pkg::ACK_NACK_STOP;
							end
						end else begin
							fail       = 1'b1;
							fail_where = PH_DATA_RX;
						end
					end
					PH_LAST_RX: begin
						res_d.rx_byte  = item.data.rx_data;
						res_d.rx_valid = 1'b1;
						res_d.rx_index = rx_cnt_q;
						rx_cnt_n       = rx_cnt_inc;
						phase_n        = PH_IDLE;
						wd_run_n       = 1'b0;
					end
					PH_IDLE: begin
						fail       = 1'b1;
						fail_where = PH_IDLE;
					end
					PH_WATCHDOG: begin
						fail       = 1'b1;
						fail_where = PH_WATCHDOG;
					end
					default: begin
					end
				endcase
			end
			i2crs_pkg::ACT_TICK: begin
				if (wd_run_q) begin
					if (wd_cnt_q <= 16'd1) begin
						wd_cnt_n   = '0;
						fail       = 1'b1;
						fail_where = PH_WATCHDOG;
					end else begin
						wd_cnt_n = wd_cnt_q - 16'd1;
					end
				end
			end
			default: begin
			end
		endcase

		// watchdog rearm goes with every START request
		if (arm) begin
			wd_cnt_n        = wd_ticks_q;
			wd_run_n        = 1'b1;
			res_d.start_req = 1'b1;
		end
		if (fail) begin
			phase_n        = PH_ERROR;
			err_phase_n    = fail_where;
			wd_run_n       = 1'b0;
			res_d.stop_req = 1'b1;
		end

		res_d.busy_res     = (phase_n != PH_IDLE) && (phase_n != PH_ERROR);
		res_d.error_flag   = (phase_n == PH_ERROR);
		res_d.failed_phase = err_phase_n;
	end

	// sequencer state, config register and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			err_phase_q <= PH_IDLE;
			bus_addr_q  <= '0;
			reg_addr_q  <= '0;
			burst_len_q <= '0;
			rx_cnt_q    <= '0;
			wd_cnt_q    <= '0;
			wd_run_q    <= 1'b0;
			wd_ticks_q  <= i2crs_pkg::WD_TICKS_RESET;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				wd_ticks_q <= cfg_wr_data;
			end
			if (item_take) begin
				phase_q     <= phase_n;
				err_phase_q <= err_phase_n;
				bus_addr_q  <= bus_addr_n;
				reg_addr_q  <= reg_addr_n;
				burst_len_q <= burst_len_n;
				rx_cnt_q    <= rx_cnt_n;
				wd_cnt_q    <= wd_cnt_n;
				wd_run_q    <= wd_run_n;
				res_q       <= res_d;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/i2c_register_read_sequencer_unit.sv */
// I2C register-read burst sequencer, one result word per input word.
// The input word is registered in the input register, then the sequencer step
// loads the result register. Throughput: 1 word per cycle unless m_tready
// stalls the output; the one-step state update sets that rate.
// Reset (arst_n low, async): sequencer idle, watchdog stopped,
// watchdog_ticks back to 1000, both registers empty.
module i2c_register_read_sequencer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [15:0]                       cfg_wr_data,   // watchdog_ticks
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// bus_addr[7:0], reg_addr[15:8], length[23:16], status[39:24], rx_data[47:40]
	input  logic [i2crs_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [1:0]                        s_tuser,       // action[1:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// tx_byte[7:0], tx_write[8], start_req[9], stop_req[10], ack_ctrl[12:11],
	// buf_irq_ctrl[14:13], rx_byte[22:15], rx_valid[23], rx_index[31:24],
	// busy_res[32], error_flag[33], failed_phase[37:34], zero[39:38]
	output logic [i2crs_pkg::OUT_DATA_W-1:0]  m_tdata
);

	i2crs_pkg::item_t   in_item, item;
	i2crs_pkg::result_t res;
	logic               item_valid, item_take;

	assign in_item.action = s_tuser;
	assign in_item.data   = s_tdata;

	i2crs_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item       (item)
	);

	i2crs_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_valid  (item_valid),
		.item_take   (item_take),
		.item        (item),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res         (res)
	);

	assign m_tdata = {2'b00, res};

endmodule

/* sv/i2crs_checker.sv */
module i2crs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// busy and error never show together
	a_busy_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[32] && m_tdata[33]))
		else $error("busy and error both set");

	// payload bytes are zero without their qualifier
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8] || m_tdata[7:0] == 8'd0) &&
			(m_tdata[23] || (m_tdata[22:15] == 8'd0 && m_tdata[31:24] == 8'd0)))
		else $error("unqualified payload not zero");

	// control codes stay in range
	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[12:11] != 2'd3 && m_tdata[14:13] != 2'd3 &&
			m_tdata[37:34] <= 4'd10)
		else $error("control code out of range");

	// STOP request only comes with the error phase, never with a START request
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10] |-> m_tdata[33] && !m_tdata[9])
		else $error("stop without error");

endmodule

bind i2c_register_read_sequencer_unit i2crs_checker u_i2crs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
